@@ hw/rtl/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, register indexes, controller states and the status bundle
// of the bit-serial modular multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // default operand width
    localparam int MEXP_WIDTH = 32;

    // configuration register index
    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_EXPONENT = 1'b0;
    localparam t_cfg_idx REG_MODULUS  = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_HOLD
    } t_state;

    // multiplier status towards the controller
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_stat;

endpackage

@@ hw/rtl/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Computes message^exponent mod modulus by left-to-right square and multiply.
// ----------------------------------------------------------------------------
// Usage:
//   Write exponent (index 0) and modulus (index 1) on the i_cfg_* port while
//   the core is idle. Send a message beat on s_axis; the result beat appears
//   on m_axis with the result in tdata and the error flag in tuser.
//   One item is in flight at a time; s_axis_tready is high only when the
//   controller is free, which may be while a previous result still waits.
//   A zero message or zero modulus (error, result 0) or a zero exponent
//   (result 1) goes straight to the hold state. Otherwise the bit-serial
//   multiplier does one reduction of the message, then a square for every
//   exponent bit and a multiply for each set bit. The next message can be
//   taken once the result is loaded into the output register.
//   Reset returns exponent and modulus to 1 and drops any item in flight.
//   When m_axis_tready is low the result beat holds; a finished result then
//   waits in the controller and no new message is taken.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int WIDTH = mexp_pkg::MEXP_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  mexp_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [WIDTH-1:0]               i_cfg_data,
    // message in; tdata: message [WIDTH-1:0], zero padded
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [((WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    // result out; tdata: result [WIDTH-1:0], zero padded
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [((WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // tuser: error [0]
    output logic                           m_axis_tuser
);
    import mexp_pkg::*;

    localparam int BIT_W = $clog2(WIDTH);

    t_state           r_state;
    t_state           n_state;
    logic [WIDTH-1:0] r_exp;
    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_base;
    logic [BIT_W-1:0] r_bitcnt;
    logic             r_err;
    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_res;
    logic             r_out_err;

    logic             in_beat;
    logic [WIDTH-1:0] msg;
    logic             bad_in;
    logic             exp_zero;
    logic             exp_bit;
    logic             last_bit;
    logic             out_free;
    logic             mm_start;
    logic [WIDTH-1:0] mm_a;
    logic [WIDTH-1:0] mm_b;
    logic [WIDTH-1:0] mm_p;
    logic [WIDTH-1:0] one_mod;
    t_mm_stat         mm_stat;

    assign msg      = s_axis_tdata[WIDTH-1:0];
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign bad_in   = (msg == '0) || (r_mod == '0);
    assign exp_zero = (r_exp == '0);
    assign exp_bit  = r_exp[r_bitcnt];
    assign last_bit = (r_bitcnt == '0);
    assign out_free = !r_out_valid || m_axis_tready;
    assign one_mod  = (r_mod == WIDTH'(1)) ? '0 : WIDTH'(1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= WIDTH'(1);
            r_mod <= WIDTH'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_EXPONENT: r_exp <= i_cfg_data;
                REG_MODULUS:  r_mod <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_state = (bad_in || exp_zero) ? ST_HOLD : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (mm_stat.done) n_state = ST_SQUARE;
            end
            ST_SQUARE: begin
                if (mm_stat.done) begin
                    if (exp_bit)       n_state = ST_MULT;
                    else if (last_bit) n_state = ST_HOLD;
                end
            end
            ST_MULT: begin
                if (mm_stat.done) n_state = last_bit ? ST_HOLD : ST_SQUARE;
            end
            ST_HOLD: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs: multiplier start and operand selection
    always_comb begin
        mm_start      = 1'b0;
        mm_a          = mm_p;
        mm_b          = mm_p;
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                // reduce the message: 1 * message mod modulus
                mm_start = in_beat && !bad_in && !exp_zero;
                mm_a     = one_mod;
                mm_b     = msg;
            end
            ST_REDUCE: begin
                mm_start = mm_stat.done;
                mm_a     = r_acc;
                mm_b     = r_acc;
            end
            ST_SQUARE: begin
                mm_start = mm_stat.done && (exp_bit || !last_bit);
                mm_a     = exp_bit ? r_base : mm_p;
                mm_b     = mm_p;
            end
            ST_MULT: begin
                mm_start = mm_stat.done && !last_bit;
            end
            ST_HOLD: ;
            default: ;
        endcase
    end

    // controller registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // running value, base and exponent bit index
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    r_err    <= bad_in;
                    r_bitcnt <= BIT_W'(WIDTH - 1);
                    if (bad_in)        r_acc <= '0;
                    else if (exp_zero) r_acc <= WIDTH'(1);
                    else               r_acc <= one_mod;
                end
            end
            ST_REDUCE: begin
                if (mm_stat.done) r_base <= mm_p;
            end
            ST_SQUARE: begin
                if (mm_stat.done) begin
                    r_acc <= mm_p;
                    if (!exp_bit && !last_bit) r_bitcnt <= r_bitcnt - BIT_W'(1);
                end
            end
            ST_MULT: begin
                if (mm_stat.done) begin
                    r_acc <= mm_p;
                    if (!last_bit) r_bitcnt <= r_bitcnt - BIT_W'(1);
                end
            end
            ST_HOLD: ;
            default: ;
        endcase
    end

    // output register: load from hold, drop on accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_HOLD && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_HOLD && out_free) begin
            r_out_res <= r_acc;
            r_out_err <= r_err;
        end
    end

    always_comb begin
        m_axis_tdata              = '0;
        m_axis_tdata[WIDTH-1:0]   = r_out_res;
    end
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_err;

    mexp_modmul #(
        .WIDTH (WIDTH)
    ) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_m     (r_mod),
        .o_stat  (mm_stat),
        .o_p     (mm_p)
    );

    // never start the multiplier while it is stepping
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_start |-> !mm_stat.busy)
        else $error("multiplier started while busy");

    // multiplier finishes only in a computing state
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_stat.done |-> (r_state == ST_REDUCE || r_state == ST_SQUARE
                          || r_state == ST_MULT))
        else $error("multiplier done outside a computing state");

    // zero message goes straight to hold with the error flag
    a_zero_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && msg == '0) |=> (r_state == ST_HOLD && r_err && r_acc == '0))
        else $error("zero message not flagged");

    // running value and base stay reduced during the power loop
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQUARE || r_state == ST_MULT)
            |-> (r_acc < r_mod && r_base < r_mod))
        else $error("running value not reduced");

endmodule

@@ hw/rtl/mexp_modmul.sv @@
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes (a * b) mod m by shift and add, one bit of b per cycle, MSB first.
// Requires a < m. Done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module mexp_modmul #(
    parameter int WIDTH = mexp_pkg::MEXP_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [WIDTH-1:0]   i_a,
    input  logic [WIDTH-1:0]   i_b,
    input  logic [WIDTH-1:0]   i_m,
    output mexp_pkg::t_mm_stat o_stat,
    output logic [WIDTH-1:0]   o_p
);
    import mexp_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0]   dbl;
    logic [WIDTH-1:0] dbl_red;
    logic [WIDTH:0]   sum;
    logic [WIDTH-1:0] sum_red;

    // double the accumulator, reduce, then add a where the bit is set
    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, i_m}) ? WIDTH'(dbl - {1'b0, i_m}) : dbl[WIDTH-1:0];
        sum     = {1'b0, dbl_red} + (r_b[WIDTH-1] ? {1'b0, r_a} : '0);
        sum_red = (sum >= {1'b0, i_m}) ? WIDTH'(sum - {1'b0, i_m}) : sum[WIDTH-1:0];
    end

    // sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH - 1);
            end
        end
    end

    // operand and accumulator registers
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_acc <= sum_red;
            r_b   <= {r_b[WIDTH-2:0], 1'b0};
        end else if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end
    end

    assign o_stat = {r_busy, r_done};
    assign o_p    = r_acc;

    // accumulator stays reduced while stepping
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_acc < i_m))
        else $error("modmul accumulator not reduced");

    // a fresh product is flagged in the cycle after the last step
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0) |=> (r_done && !r_busy))
        else $error("modmul done not raised after last step");

    // done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("modmul done held longer than one cycle");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives message beats and key writes into the core and holds its own
// square-and-multiply model. Each result beat is compared field by field
// with the oldest outstanding expectation. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import mexp_pkg::*;

    localparam int W          = MEXP_WIDTH;
    localparam int TDATA_W    = ((W + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 10000;
    localparam int RAND_ITEMS = 256;

    typedef struct packed {
        bit [W-1:0] result;
        bit         error;
    } t_power;

    // Key copy, modular power predictor and the queue of outstanding results
    class modpow_scoreboard;
        bit [W-1:0] exponent;
        bit [W-1:0] modulus;
        t_power     pending_results[$];
        int         fails;

        function new();
            exponent = 1;
            modulus  = 1;
            fails    = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, bit [W-1:0] value);
            case (idx)
                REG_EXPONENT: exponent = value;
                REG_MODULUS:  modulus  = value;
                default: ;
            endcase
        endfunction

        // left-to-right square and multiply with exact double-width products
        function t_power mod_power(bit [W-1:0] msg);
            t_power     p;
            bit [63:0]  acc;
            bit [63:0]  base;
            bit [63:0]  m;
            m = 64'(modulus);
            if (msg == 0 || modulus == 0) begin
                p.result = '0;
                p.error  = 1'b1;
                return p;
            end
            p.error = 1'b0;
            if (exponent == 0) begin
                p.result = W'(1);
                return p;
            end
            base = 64'(msg) % m;
            acc  = 64'd1 % m;
            for (int i = W - 1; i >= 0; i--) begin
                acc = (acc * acc) % m;
                if (exponent[i])
                    acc = (acc * base) % m;
            end
            p.result = acc[W-1:0];
            return p;
        endfunction

        function void note_message(bit [W-1:0] msg);
            pending_results.push_back(mod_power(msg));
        endfunction

        function void check_result(bit [W-1:0] result, bit err);
            t_power want;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing outstanding: result=%h error=%0b",
                       result, err);
                fails++;
                return;
            end
            want = pending_results.pop_front();
            if (result !== want.result) begin
                $error("result: expected %h, got %h", want.result, result);
                fails++;
            end
            if (err !== want.error) begin
                $error("error: expected %0b, got %0b", want.error, err);
                fails++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    t_cfg_idx           i_cfg_idx = REG_EXPONENT;
    logic [W-1:0]       i_cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;

    modpow_scoreboard sb = new();
    bit               steady = 1'b0;

    modular_exponentiation #(
        .WIDTH(W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // End the run when no beat moves on either side for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
                (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("modular_exponentiation: mismatch");
                $finish;
            end
        end
    end

    // Result sink: stall each beat at random, then check it
    initial begin : result_sink
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 6);
            @(negedge i_clk);
            if (stall == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
                repeat (stall) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            sb.check_result(m_axis_tdata[W-1:0], m_axis_tuser);
        end
    end

    // Drop valid and hold until every outstanding result has arrived
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Load a new key once the core has gone idle
    task automatic set_key(bit [W-1:0] exponent, bit [W-1:0] modulus);
        drain();
        repeat (4) @(posedge i_clk);
        write_reg(REG_EXPONENT, exponent);
        write_reg(REG_MODULUS, modulus);
    endtask

    // Send one message beat after a random gap and note it once accepted
    task automatic send_message(bit [W-1:0] msg);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(msg);
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_message(msg);
    endtask

    initial begin : stimulus
        bit [W-1:0] exponent;
        bit [W-1:0] modulus;
        bit [W-1:0] msg;
        int         sent;
        int         count;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset key: exponent 1, modulus 1
        send_message(32'd5);
        send_message(32'd0);

        // zero exponent gives one, even with modulus one
        set_key(32'd0, 32'd1);
        send_message(32'd7);
        send_message(32'd0);
        set_key(32'd0, 32'hFFFF_FFFF);
        send_message(32'hFFFF_FFFF);

        // zero modulus flags an error whatever the message
        set_key(32'hFFFF_FFFF, 32'd0);
        send_message(32'd3);
        send_message(32'd0);

        // all-ones exponent and modulus, back to back
        steady = 1'b1;
        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_message(32'hFFFF_FFFF);
        send_message(32'hFFFF_FFFE);
        send_message(32'd2);
        steady = 1'b0;

        // textbook key, messages below, at and above the modulus
        set_key(32'd65537, 32'd3233);
        send_message(32'd65);
        send_message(32'd3233);
        send_message(32'd3300);
        send_message(32'd1);
        send_message(32'h8000_0000);

        set_key(32'd2, 32'd2);
        send_message(32'd3);
        send_message(32'd2);

        // random keys, each followed by a burst of messages
        sent = 0;
        while (sent < RAND_ITEMS) begin
            case ($urandom_range(0, 7))
                0: exponent = 32'd0;
                1: exponent = $urandom_range(1, 3);
                2: exponent = 32'd65537;
                3: exponent = 32'hFFFF_FFFF;
                4: exponent = $urandom_range(0, 16'hFFFF);
                default: exponent = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0: modulus = 32'd0;
                1: modulus = 32'd1;
                2: modulus = $urandom_range(2, 64);
                3: modulus = 32'hFFFF_FFFF;
                4: modulus = 32'hFFFF_FFFB;
                5: modulus = 32'd1 << $urandom_range(1, 31);
                6: modulus = $urandom | 32'd1;
                7: modulus = $urandom_range(2, 16'hFFFF);
                default: modulus = $urandom;
            endcase
            set_key(exponent, modulus);
            steady = ($urandom_range(0, 3) == 0);
            count  = $urandom_range(8, 24);
            repeat (count) begin
                case ($urandom_range(0, 11))
                    0: msg = 32'd0;
                    1: msg = 32'hFFFF_FFFF;
                    2: msg = $urandom_range(1, 15);
                    3: msg = modulus - 32'd1;
                    4: msg = modulus;
                    5: msg = modulus + $urandom_range(1, 1000);
                    default: msg = $urandom;
                endcase
                // now and then hold off until the core has emptied
                if ($urandom_range(0, 19) == 0)
                    drain();
                send_message(msg);
                sent++;
            end
            steady = 1'b0;
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending_results.size() == 0)
            $display("modular_exponentiation: match");
        else
            $display("modular_exponentiation: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_modmul.sv
hw/rtl/modular_exponentiation.sv
sim/tb_top.sv
